// File: rtl/hpgov_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the core hotplug load governor.
// No dependencies; imported by every module of the block.
package hpgov_pkg;

  // Cores in the system; the governor models at most four of them.
  localparam int unsigned NumCores  = 4;
  localparam int unsigned CoresUsed = (NumCores > 4) ? 4 : NumCores;
  localparam logic [3:0]  AllMask   = 4'((1 << CoresUsed) - 1);
  localparam logic [2:0]  CoresUsedW = 3'(CoresUsed);

  localparam logic [6:0] LoadMax    = 7'd100;
  localparam logic [6:0] BurstLoad  = 7'd95;
  localparam logic [5:0] BurstMinUp = 6'd2;
  localparam logic [2:0] MinCores   = 3'd2;
  localparam logic [5:0] CountCap   = 6'd40;
  localparam logic [5:0] CounterMax = 6'd63;

  // floor(x / 3) == (x * 171) >> 9 for every sum of four loads (x <= 400)
  localparam logic [16:0] Recip3      = 17'd171;
  localparam int unsigned Recip3Shift = 9;

  typedef enum logic [2:0] {
    REG_GOVERNOR_ON     = 3'd0,
    REG_UP_THRESHOLD    = 3'd1,
    REG_CORE_LIMIT      = 3'd2,
    REG_UP_COUNT_LIMIT  = 3'd3,
    REG_DOWN_COUNT_LIMIT = 3'd4,
    REG_PLUG_EVERYTHING = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_PLUG   = 2'd1,
    ACT_UNPLUG = 2'd2
  } action_e;

  // Clamped configuration as seen by the datapath.
  typedef struct packed {
    logic       gov_on;
    logic [6:0] thr;
    logic [2:0] lim;
    logic [5:0] ulim;
    logic [5:0] dlim;
    logic       plug_every;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic average;
    logic decide;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic run;
  } status_t;

  function automatic logic [6:0] sat_load(logic [6:0] v);
    return (v > LoadMax) ? LoadMax : v;
  endfunction

  function automatic logic [5:0] sat_inc(logic [5:0] v);
    return (v >= CounterMax) ? CounterMax : v + 6'd1;
  endfunction

endpackage

// File: rtl/hpgov_dp.sv
`timescale 1ns / 1ps
// Datapath of the hotplug governor: load capture, averaging, counters,
// mask decision and the output register. Depends on hpgov_pkg.
module hpgov_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hpgov_pkg::cfg_t      cfg_i,
  input  logic                 hold_all_i,
  input  hpgov_pkg::cmd_t      cmd_i,
  output hpgov_pkg::status_t   status_o,
  input  logic [3:0][6:0]      load_i,
  output logic [3:0]           online_cores_o,
  output logic [1:0]           action_o,
  output logic [1:0]           affected_core_o,
  output logic [6:0]           average_load_o,
  output logic [5:0]           up_counter_now_o,
  output logic [5:0]           down_counter_now_o
);
  import hpgov_pkg::*;

  // governor state
  logic [3:0] mask_q, mask_d;
  logic [5:0] up_q, up_d;
  logic [5:0] dn_q, dn_d;

  // per-tick working registers
  logic [3:0][6:0] load_q;
  logic [6:0]      avg_q;
  logic [2:0]      n_q;
  action_e         act_q, act_d;
  logic [1:0]      core_q, core_d;

  logic [3:0]  keep_w;
  logic [8:0]  sum_w;
  logic [16:0] prod_w;
  logic [6:0]  avg_w;
  logic [2:0]  n_w;
  logic        plug_w, unplug_w, found_w;
  logic [6:0]  best_w;
  logic [1:0]  pick_w;

  assign status_o.run = cfg_i.gov_on && (cfg_i.lim != MinCores);

  // cores below the limit keep their online bit
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      keep_w[i] = (3'(i) < cfg_i.lim);
    end
  end

  // sum and mean over online cores
  always_comb begin
    sum_w = 9'd0;
    for (int i = 0; i < 4; i++) begin
      if (mask_q[i]) begin
        sum_w = sum_w + 9'(load_q[i]);
      end
    end
    n_w    = 3'($countones(mask_q));
    prod_w = {8'd0, sum_w} * Recip3;
    case (n_w)
      3'd1:    avg_w = 7'(sum_w);
      3'd2:    avg_w = 7'(sum_w >> 1);
      3'd3:    avg_w = 7'(prod_w >> Recip3Shift);
      3'd4:    avg_w = 7'(sum_w >> 2);
      default: avg_w = 7'd0;
    endcase
  end

  // hysteresis counters and plug / unplug choice
  always_comb begin
    up_d     = up_q;
    dn_d     = dn_q;
    mask_d   = mask_q;
    act_d    = act_q;
    core_d   = core_q;
    plug_w   = 1'b0;
    unplug_w = 1'b0;
    found_w  = 1'b0;
    best_w   = LoadMax + 7'd1;
    pick_w   = 2'd0;

    if (cmd_i.capture) begin
      act_d  = ACT_NONE;
      core_d = 2'd0;
      if (!cfg_i.gov_on) begin
        mask_d = AllMask;
        up_d   = 6'd0;
        dn_d   = 6'd0;
      end else begin
        mask_d = (mask_q & keep_w) | 4'b0011;
      end
    end else if (cmd_i.decide) begin
      if (cfg_i.plug_every) begin
        plug_w = (n_q < CoresUsedW);
      end else if (avg_q >= cfg_i.thr) begin
        up_d   = sat_inc(up_q);
        plug_w = (up_d > cfg_i.ulim);
      end else if ((avg_q > BurstLoad) && (up_q >= BurstMinUp)) begin
        up_d   = sat_inc(up_q);
        plug_w = 1'b1;
      end else begin
        dn_d     = sat_inc(dn_q);
        unplug_w = (dn_d > cfg_i.dlim);
      end

      if (plug_w) begin
        if (n_q < cfg_i.lim) begin
          for (int i = 1; i < 4; i++) begin
            if ((i < CoresUsed) && !mask_q[i] && !found_w) begin
              found_w   = 1'b1;
              mask_d[i] = 1'b1;
              act_d     = ACT_PLUG;
              core_d    = 2'(i);
            end
          end
        end
        up_d = 6'd0;
        dn_d = 6'd0;
      end else if (unplug_w) begin
        if (n_q > MinCores) begin
          for (int i = 2; i < 4; i++) begin
            if ((i < CoresUsed) && mask_q[i] && (load_q[i] < best_w)) begin
              best_w = load_q[i];
              pick_w = 2'(i);
            end
          end
          if (pick_w > 2'd1) begin
            mask_d[pick_w] = 1'b0;
            act_d          = ACT_UNPLUG;
            core_d         = pick_w;
          end
        end
        up_d = 6'd0;
        dn_d = 6'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= AllMask;
      up_q   <= 6'd0;
      dn_q   <= 6'd0;
    end else if (hold_all_i) begin
      mask_q <= AllMask;
      up_q   <= 6'd0;
      dn_q   <= 6'd0;
    end else begin
      mask_q <= mask_d;
      up_q   <= up_d;
      dn_q   <= dn_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    core_q <= core_d;
    if (cmd_i.capture) begin
      for (int i = 0; i < 4; i++) begin
        load_q[i] <= sat_load(load_i[i]);
      end
    end
    if (cmd_i.average) begin
      avg_q <= avg_w;
      n_q   <= n_w;
    end
    if (cmd_i.emit) begin
      online_cores_o     <= mask_q;
      action_o           <= act_q;
      affected_core_o    <= core_q;
      average_load_o     <= avg_q;
      up_counter_now_o   <= up_q;
      down_counter_now_o <= dn_q;
    end
  end

endmodule

// File: rtl/hpgov_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the hotplug governor: steps one tick through the datapath
// and owns the input stall and the output valid. Depends on hpgov_pkg.
module hpgov_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  hpgov_pkg::status_t status_i,
  output hpgov_pkg::cmd_t    cmd_o
);
  import hpgov_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_AVG    = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free_w;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free_w  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && out_stall_i;
    cmd_o         = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_AVG;
        end
      end
      ST_AVG: begin
        cmd_o.average = 1'b1;
        state_d       = status_i.run ? ST_DECIDE : ST_EMIT;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (out_free_w) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core_hotplug_load_governor.sv
`timescale 1ns / 1ps
// Core hotplug load governor: top level with configuration registers.
// Depends on hpgov_pkg, hpgov_ctrl and hpgov_dp.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o): one transaction per tick, with
//    a load percent per core. Loads above 100 are taken as 100.
//  - Output channel (out_valid_o / out_stall_i): one transaction per tick with
//    the online mask, the plug/unplug action, the affected core, the mean load
//    and both hysteresis counters.
//  - Config channel (cfg_valid_i / cfg_ready_o): index plus data, always ready.
//    Write only while no tick is in flight. Writing 0 to governor_on brings
//    all cores online and clears both counters at once.
//  - Steps: after input accept a tick passes the average, decide and emit
//    steps before output valid; decide is skipped when the governor is off or
//    the core limit is 2. A new tick is not taken until its predecessor is handed
//    to the output register, and is taken in the cycle after that.
//  - The output register parts the two sides: the next tick is accepted while
//    an earlier result waits; when the receiver stalls, the result is held
//    and a finished tick waits in its last step until the register frees.
//  - Reset: governor off, default thresholds, all cores online, counters 0.
module core_hotplug_load_governor (
  input  logic       clk_i,
  input  logic       rst_ni,
  // tick input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [6:0] load_core0_i,
  input  logic [6:0] load_core1_i,
  input  logic [6:0] load_core2_i,
  input  logic [6:0] load_core3_i,
  // result output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [3:0] online_cores_o,
  output logic [1:0] action_o,
  output logic [1:0] affected_core_o,
  output logic [6:0] average_load_o,
  output logic [5:0] up_counter_now_o,
  output logic [5:0] down_counter_now_o,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [6:0] cfg_data_i
);
  import hpgov_pkg::*;

  // Raw configuration registers
  logic       gov_on_q;
  logic [6:0] thr_q;
  logic [2:0] lim_q;
  logic [5:0] ulim_q;
  logic [5:0] dlim_q;
  logic       plug_every_q;

  logic       cfg_we_w;
  logic       hold_all_w;
  cfg_t       cfg_w;
  cmd_t       cmd_w;
  status_t    status_w;

  assign cfg_ready_o = 1'b1;
  assign cfg_we_w    = cfg_valid_i && cfg_ready_o;

  // Turning the governor off drops every core back online right away.
  assign hold_all_w = cfg_we_w && (cfg_index_i == REG_GOVERNOR_ON) && !cfg_data_i[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gov_on_q     <= 1'b0;
      thr_q        <= 7'd85;
      lim_q        <= 3'd4;
      ulim_q       <= 6'd5;
      dlim_q       <= 6'd10;
      plug_every_q <= 1'b0;
    end else if (cfg_we_w) begin
      case (cfg_index_i)
        REG_GOVERNOR_ON:      gov_on_q     <= cfg_data_i[0];
        REG_UP_THRESHOLD:     thr_q        <= cfg_data_i;
        REG_CORE_LIMIT:       lim_q        <= cfg_data_i[2:0];
        REG_UP_COUNT_LIMIT:   ulim_q       <= cfg_data_i[5:0];
        REG_DOWN_COUNT_LIMIT: dlim_q       <= cfg_data_i[5:0];
        REG_PLUG_EVERYTHING:  plug_every_q <= cfg_data_i[0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  // Clamp the settings into their working ranges.
  always_comb begin
    cfg_w.gov_on     = gov_on_q;
    cfg_w.thr        = (thr_q > LoadMax) ? LoadMax : thr_q;
    cfg_w.ulim       = (ulim_q > CountCap) ? CountCap : ulim_q;
    cfg_w.dlim       = (dlim_q > CountCap) ? CountCap : dlim_q;
    cfg_w.plug_every = plug_every_q;
    if (lim_q < MinCores) begin
      cfg_w.lim = MinCores;
    end else if (lim_q > CoresUsedW) begin
      cfg_w.lim = CoresUsedW;
    end else begin
      cfg_w.lim = lim_q;
    end
  end

  hpgov_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_w),
    .cmd_o       (cmd_w)
  );

  hpgov_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_w),
    .hold_all_i         (hold_all_w),
    .cmd_i              (cmd_w),
    .status_o           (status_w),
    .load_i             ({load_core3_i, load_core2_i, load_core1_i, load_core0_i}),
    .online_cores_o     (online_cores_o),
    .action_o           (action_o),
    .affected_core_o    (affected_core_o),
    .average_load_o     (average_load_o),
    .up_counter_now_o   (up_counter_now_o),
    .down_counter_now_o (down_counter_now_o)
  );

  // A tick occupies the sequencer for the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted two cycles in a row");

  // Cores 0 and 1 stay online in every result.
  a_boot_cores_online: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> online_cores_o[1:0] == 2'b11)
    else $error("core 0 or 1 reported offline");

  // No action means no affected core; the action code stays legal.
  a_action_core: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ACT_NONE) |-> affected_core_o == 2'd0)
    else $error("affected core set without an action");

  a_action_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (action_o == ACT_NONE) || (action_o == ACT_PLUG) ||
                    (action_o == ACT_UNPLUG))
    else $error("illegal action code");

endmodule
